// ===== hw/rtl/sobel_pkg.sv =====
// Shared constants, types and the square-root step of the Sobel edge magnitude core.
package sobel_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam int PIX_W     = 8;
    localparam int POS_W     = 11;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 4;
    localparam int SQR_W     = 20;
    localparam int ROOT_STEPS = 8;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_W-1:0] RESET_IMAGE_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RESET_IMAGE_HEIGHT = 12'd480;

    localparam logic [PIX_W-1:0] EDGE_SAT = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    // Position and flags that travel with a request through the pipeline.
    typedef struct packed {
        logic             calc;
        logic             sat;
        logic             done;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_meta;

    // Partial state of the digit-by-digit square root.
    typedef struct packed {
        logic [9:0]  rem;
        logic [7:0]  root;
        logic [15:0] val;
    } t_root;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [PIX_W-1:0] edge_value;
    } t_result;

    // One result bit of the integer square root, taking the next two radicand bits.
    function automatic t_root root_step(t_root a);
        t_root      b;
        logic [9:0] rem_sh;
        logic [9:0] trial;
        rem_sh = {a.rem[7:0], a.val[15:14]};
        trial  = {a.root, 2'b01};
        b.val  = {a.val[13:0], 2'b00};
        if (rem_sh >= trial) begin
            b.rem  = rem_sh - trial;
            b.root = {a.root[6:0], 1'b1};
        end else begin
            b.rem  = rem_sh;
            b.root = {a.root[6:0], 1'b0};
        end
        return b;
    endfunction

endpackage

// ===== hw/rtl/sobel_edge_magnitude_core.sv =====
// Top level of the streaming 3x3 Sobel edge magnitude core.
//
//  Channel  Direction  Payload
//  s_axis   in         tdata[7:0] gray_pixel
//  m_axis   out        tdata[7:0] edge_value, [18:8] out_row, [29:19] out_col; tlast frame_done
//  cfg      in         index 0 image_width, 1 image_height; data[11:0]
//
// One pixel is taken per cycle while the skid stage is empty; a result passes through the
// line-store read, the window stage, the squaring stage, the eight-step root pipe and the
// output register.
// Both line stores share one RAM entry per column, read when a pixel is taken and written back
// from stage 1 as the pipeline advances, so a column is never read while its write is pending.
// A stalled output fills a one-entry skid stage; the input stops only when that is full.
// Reset is synchronous; line store contents are not cleared and need no clearing pass.
module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [sobel_pkg::PIX_W-1:0]     i_s_axis_tdata,   // [7:0] gray_pixel
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [sobel_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,  // [7:0] edge_value,
                                                              // [18:8] out_row,
                                                              // [29:19] out_col, zeros
    output logic                            o_m_axis_tlast,   // frame_done
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sobel_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sobel_pkg::CFG_W-1:0]     i_cfg_data
);
    import sobel_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WD_W   = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
    localparam int HT_W   = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1);
    localparam int LINE_W = 2 * PIX_W;

    // Configuration
    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;
    logic             cfg_we;
    logic             cfg_hit;
    logic [WD_W-1:0]  w_raw;
    logic [WD_W-1:0]  w_eff;
    logic [HT_W-1:0]  h_raw;
    logic [HT_W-1:0]  h_eff;

    // Position counters
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic             last_col;
    logic             last_row;
    logic             en;
    logic             acc;
    t_meta            in_meta;
    logic             in_emit;

    // Stage 1: line store read in flight
    logic             r_s1_v;
    logic             r_s1_emit;
    logic [COL_W-1:0] r_s1_addr;
    logic [PIX_W-1:0] r_s1_px;
    t_meta            r_s1_meta;
    logic [LINE_W-1:0] ram_rdata;
    logic [LINE_W-1:0] ram_wdata;
    logic             ram_we;

    // Stage 2: window
    logic [PIX_W-1:0] r_win [3][3];
    logic             r_s2_v;
    t_meta            r_s2_meta;

    // Stage 3: squared gradients
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [9:0]         ax;
    logic [9:0]         ay;
    logic               r_s3_v;
    t_meta              r_s3_meta;
    logic [SQR_W-1:0]   r_s3_sqx;
    logic [SQR_W-1:0]   r_s3_sqy;
    logic [SQR_W:0]     sq_sum;
    t_root              q_in;
    t_meta              q_in_meta;

    // Root pipe
    logic  r_q_v    [ROOT_STEPS];
    t_meta r_q_meta [ROOT_STEPS];
    t_root r_q      [ROOT_STEPS];

    // Output and skid
    logic    p_v;
    t_result p_data;
    logic    r_out_v;
    t_result r_out;
    logic    r_skid_v;
    t_result r_skid;

    assign o_cfg_ready = 1'b1;
    assign cfg_we  = i_cfg_valid && o_cfg_ready;
    assign cfg_hit = cfg_we && (i_cfg_index == REG_IMAGE_WIDTH ||
                                i_cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RESET_IMAGE_WIDTH;
            r_cfg_height <= RESET_IMAGE_HEIGHT;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame dimensions in use are the registers saturated to the supported range.
    always_comb begin
        w_raw = WD_W'(r_cfg_width);
        h_raw = HT_W'(r_cfg_height);
        if (w_raw < WD_W'(3)) begin
            w_eff = WD_W'(3);
        end else if (w_raw > WD_W'(MAX_WIDTH)) begin
            w_eff = WD_W'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (h_raw < HT_W'(3)) begin
            h_eff = HT_W'(3);
        end else if (h_raw > HT_W'(MAX_HEIGHT)) begin
            h_eff = HT_W'(MAX_HEIGHT);
        end else begin
            h_eff = h_raw;
        end
    end

    assign en              = !r_skid_v;
    assign o_s_axis_tready = en;
    assign acc             = i_s_axis_tvalid && en;

    always_comb begin
        last_col = (WD_W'(r_col) + WD_W'(1)) >= w_eff;
        last_row = (HT_W'(r_row) + HT_W'(1)) >= h_eff;
        n_col    = last_col ? '0 : r_col + COL_W'(1);
        n_row    = r_row;
        if (last_col) begin
            n_row = last_row ? '0 : r_row + ROW_W'(1);
        end
        in_emit      = (r_row != '0) && (r_col != '0);
        in_meta.calc = (r_row > ROW_W'(1)) && (r_col > COL_W'(1));
        in_meta.sat  = 1'b0;
        in_meta.done = last_col && last_row;
        in_meta.row  = POS_W'(r_row - ROW_W'(1));
        in_meta.col  = POS_W'(r_col - COL_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Each entry holds the older line in the upper byte and the newer line in the lower.
    assign ram_we    = en && r_s1_v;
    assign ram_wdata = {ram_rdata[PIX_W-1:0], r_s1_px};

    sobel_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (ram_wdata),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Window shift happens together with the write-back of the same column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (en && r_s1_v) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= ram_rdata[LINE_W-1:PIX_W];
            r_win[1][2] <= ram_rdata[PIX_W-1:0];
            r_win[2][2] <= r_s1_px;
        end
    end

    always_comb begin
        gx = 11'({3'b0, r_win[0][2]} + {2'b0, r_win[1][2], 1'b0} + {3'b0, r_win[2][2]})
           - 11'({3'b0, r_win[0][0]} + {2'b0, r_win[1][0], 1'b0} + {3'b0, r_win[2][0]});
        gy = 11'({3'b0, r_win[2][0]} + {2'b0, r_win[2][1], 1'b0} + {3'b0, r_win[2][2]})
           - 11'({3'b0, r_win[0][0]} + {2'b0, r_win[0][1], 1'b0} + {3'b0, r_win[0][2]});
        ax = gx[10] ? 10'(-gx) : gx[9:0];
        ay = gy[10] ? 10'(-gy) : gy[9:0];
    end

    always_comb begin
        sq_sum        = {1'b0, r_s3_sqx} + {1'b0, r_s3_sqy};
        q_in.rem      = '0;
        q_in.root     = '0;
        q_in.val      = sq_sum[15:0];
        q_in_meta     = r_s3_meta;
        q_in_meta.sat = |sq_sum[SQR_W:16];
    end

    // Pipeline valid bits; items that give no result leave after the line-store read stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            for (int k = 0; k < ROOT_STEPS; k++) begin
                r_q_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_s1_v   <= acc;
            r_s2_v   <= r_s1_v && r_s1_emit;
            r_s3_v   <= r_s2_v;
            r_q_v[0] <= r_s3_v;
            for (int k = 1; k < ROOT_STEPS; k++) begin
                r_q_v[k] <= r_q_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_emit   <= in_emit;
            r_s1_addr   <= r_col;
            r_s1_px     <= i_s_axis_tdata;
            r_s1_meta   <= in_meta;
            r_s2_meta   <= r_s1_meta;
            r_s3_meta   <= r_s2_meta;
            r_s3_sqx    <= ax * ax;
            r_s3_sqy    <= ay * ay;
            r_q[0]      <= root_step(q_in);
            r_q_meta[0] <= q_in_meta;
            for (int k = 1; k < ROOT_STEPS; k++) begin
                r_q[k]      <= root_step(r_q[k-1]);
                r_q_meta[k] <= r_q_meta[k-1];
            end
        end
    end

    always_comb begin
        p_v         = r_q_v[ROOT_STEPS-1];
        p_data.done = r_q_meta[ROOT_STEPS-1].done;
        p_data.row  = r_q_meta[ROOT_STEPS-1].row;
        p_data.col  = r_q_meta[ROOT_STEPS-1].col;
        if (!r_q_meta[ROOT_STEPS-1].calc) begin
            p_data.edge_value = '0;
        end else if (r_q_meta[ROOT_STEPS-1].sat) begin
            p_data.edge_value = EDGE_SAT;
        end else begin
            p_data.edge_value = r_q[ROOT_STEPS-1].root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_axis_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= p_v;
            end
        end else if (p_v && en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_axis_tready) begin
            r_out <= r_skid_v ? r_skid : p_data;
        end else if (p_v && en) begin
            r_skid <= p_data;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {2'b00, r_out.col, r_out.row, r_out.edge_value};
    assign o_m_axis_tlast  = r_out.done;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage holds a result while the output register is empty");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WD_W'(r_col) < w_eff)
        else $error("column counter beyond the frame width");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        HT_W'(r_row) < h_eff)
        else $error("row counter beyond the frame height");

endmodule

// ===== hw/rtl/sobel_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
